/* design/lspe_pkg.sv */
// shared types and constants for the lsb stego payload extractor
// no dependencies; used by every module of the block
package lspe_pkg;

  localparam int NAME_BYTES   = 12;
  localparam int LENGTH_BYTES = 4;

  // entries in the byte queue between front and back, power of two
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] SEC_NAME    = 2'd0;
  localparam logic [1:0] SEC_LENGTH  = 2'd1;
  localparam logic [1:0] SEC_PAYLOAD = 2'd2;
  localparam logic [1:0] SEC_IDLE    = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_of_image;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] byte_section;
    logic       length_error;
    logic       last;
  } byte_out_t;

  // assembled byte plus a flag that its first pixel restarted the frame
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } q_entry_t;

endpackage

/* design/lspe_front.sv */
// front end: accepts pixels and packs their low bit pairs into bytes
// depends on lspe_pkg
module lspe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lspe_pkg::pixel_in_t in_data,
  input  logic                q_full,
  output logic                push,
  output lspe_pkg::q_entry_t  push_data
);

  logic [1:0] pix_cnt_r, pix_cnt_nxt;
  logic [5:0] acc_r, acc_nxt;
  logic       restart_r, restart_nxt;
  logic       accept;
  logic [1:0] cnt_eff;
  logic [5:0] acc_eff;
  logic [1:0] pair;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pair     = in_data.pixel[1:0];

  // a start of image drops any partial byte, this pixel becomes the first
  assign cnt_eff = in_data.start_of_image ? 2'd0 : pix_cnt_r;
  assign acc_eff = in_data.start_of_image ? 6'd0 : acc_r;

  always_comb begin
    pix_cnt_nxt         = pix_cnt_r;
    acc_nxt             = acc_r;
    restart_nxt         = restart_r;
    push                = 1'b0;
    push_data.data_byte = {acc_eff, pair};
    push_data.restart   = restart_r;
    if (accept) begin
      if (cnt_eff != 2'd3) begin
        acc_nxt     = {acc_eff[3:0], pair};
        pix_cnt_nxt = cnt_eff + 2'd1;
        if (cnt_eff == 2'd0) begin
          restart_nxt = in_data.start_of_image;
        end
      end else begin
        push        = 1'b1;
        acc_nxt     = 6'd0;
        pix_cnt_nxt = 2'd0;
        restart_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= 2'd0;
      acc_r     <= 6'd0;
      restart_r <= 1'b0;
    end else begin
      pix_cnt_r <= pix_cnt_nxt;
      acc_r     <= acc_nxt;
      restart_r <= restart_nxt;
    end
  end

endmodule

/* design/lspe_queue.sv */
// short byte queue between front and back
// depends on lspe_pkg
module lspe_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  lspe_pkg::q_entry_t            push_data,
  input  logic                          pop,
  output lspe_pkg::q_entry_t            head,
  output logic                          empty,
  output logic                          full,
  output logic [lspe_pkg::QCNT_W-1:0]   count
);

  lspe_pkg::q_entry_t               mem_r [lspe_pkg::QUEUE_DEPTH];
  logic [lspe_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lspe_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lspe_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == lspe_pkg::QCNT_W'(lspe_pkg::QUEUE_DEPTH));
  assign count   = cnt_r;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* design/lspe_back.sv */
// back end: frames bytes into name, length and payload, drives the result register
// depends on lspe_pkg
module lspe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lspe_pkg::q_entry_t  head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lspe_pkg::byte_out_t out_data
);

  logic [1:0]          phase_r, phase_nxt;
  logic [31:0]         cnt_r, cnt_nxt;
  logic [31:0]         len_r, len_nxt;
  logic                out_valid_r, out_valid_nxt;
  lspe_pkg::byte_out_t out_data_r, out_data_nxt;

  logic [1:0]          eff_phase;
  logic [31:0]         eff_cnt;
  logic [31:0]         eff_len;
  logic [31:0]         cnt_inc;
  logic [31:0]         len_new;
  logic [31:0]         shifted;
  logic                out_free;
  logic                drop;
  logic                emit;
  lspe_pkg::byte_out_t res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a restart byte sees cleared framing state
  assign eff_phase = head.restart ? lspe_pkg::SEC_NAME : phase_r;
  assign eff_cnt   = head.restart ? 32'd0 : cnt_r;
  assign eff_len   = head.restart ? 32'd0 : len_r;
  assign cnt_inc   = eff_cnt + 32'd1;

  assign out_free = !out_valid_r || !out_stall;
  assign drop     = (eff_phase == lspe_pkg::SEC_IDLE);
  assign pop      = !q_empty && (drop || out_free);
  assign emit     = pop && !drop;

  always_comb begin
    case (eff_cnt[1:0])
      2'd0:    shifted = {24'd0, head.data_byte};
      2'd1:    shifted = {16'd0, head.data_byte, 8'd0};
      2'd2:    shifted = {8'd0, head.data_byte, 16'd0};
      default: shifted = {head.data_byte, 24'd0};
    endcase
    len_new = eff_len | shifted;
  end

  always_comb begin
    phase_nxt        = eff_phase;
    cnt_nxt          = cnt_inc;
    len_nxt          = eff_len;
    res.data_byte    = head.data_byte;
    res.byte_section = eff_phase;
    res.length_error = 1'b0;
    res.last         = 1'b0;
    case (eff_phase)
      lspe_pkg::SEC_NAME: begin
        if (cnt_inc >= 32'(lspe_pkg::NAME_BYTES)) begin
          phase_nxt = lspe_pkg::SEC_LENGTH;
          cnt_nxt   = 32'd0;
        end
      end
      lspe_pkg::SEC_LENGTH: begin
        len_nxt = len_new;
        if (cnt_inc >= 32'(lspe_pkg::LENGTH_BYTES)) begin
          cnt_nxt = 32'd0;
          // zero or negative length ends the frame
          if (len_new == 32'd0 || len_new[31]) begin
            res.length_error = 1'b1;
            phase_nxt        = lspe_pkg::SEC_IDLE;
          end else begin
            phase_nxt = lspe_pkg::SEC_PAYLOAD;
          end
        end
      end
      lspe_pkg::SEC_PAYLOAD: begin
        if (cnt_inc >= eff_len || head.data_byte == 8'd0) begin
          res.last  = 1'b1;
          phase_nxt = lspe_pkg::SEC_IDLE;
        end
      end
      default: begin
        cnt_nxt = eff_cnt;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lspe_pkg::SEC_NAME;
      cnt_r       <= 32'd0;
      len_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/lsb_stego_payload_extractor_top.sv */
// Pixels are taken one per clock, without a gap, as long as the four-entry byte
// queue between front and back has room; in_stall rises only when that queue is
// full, which happens when results are held off by out_stall. Every fourth pixel
// completes a byte; the queue takes that byte when its last pixel is transferred,
// and the framing stage loads it into the output register once that register is
// free. Results leave at up to one per clock while out_stall is low. There is
// no clearing pass after reset: decoding starts at once with the name section.
// top level: lspe_front, lspe_queue and lspe_back; depends on lspe_pkg
module lsb_stego_payload_extractor_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lspe_pkg::pixel_in_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lspe_pkg::byte_out_t out_data
);

  logic                           push;
  lspe_pkg::q_entry_t             push_data;
  logic                           pop;
  lspe_pkg::q_entry_t             head;
  logic                           q_empty;
  logic                           q_full;
  logic [lspe_pkg::QCNT_W-1:0]    q_count;

  lspe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  lspe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  lspe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a completed byte must always find room in the queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("byte pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= lspe_pkg::QCNT_W'(lspe_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_error_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.length_error |-> out_data.byte_section == lspe_pkg::SEC_LENGTH)
    else $error("length error outside the length section");

  a_last_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.byte_section == lspe_pkg::SEC_PAYLOAD)
    else $error("last mark outside the payload section");

endmodule
